/* sv/fsgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsgs_pkg: shared definitions for the falling sand grid engine
// Grid geometry, field widths, command and register codes, and the command
// and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 400;
  localparam int GRID_HEIGHT = 400;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int XW          = $clog2(GRID_WIDTH);
  localparam int YW          = $clog2(GRID_HEIGHT);
  localparam int AW          = $clog2(CELL_COUNT);

  // port field widths
  localparam int CMD_W      = 2;
  localparam int MOUSE_W    = 11;
  localparam int CELL_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int RADIUS_W   = 7;
  localparam int COIN_W     = 32;

  // brush arithmetic: pixel offsets, their squares and the threshold
  localparam int PIX_W = XW + 2;
  localparam int DW    = ((PIX_W > MOUSE_W) ? PIX_W : MOUSE_W) + 1;
  localparam int SQ_W  = 2 * DW;
  localparam int SUM_W = SQ_W + 1;
  localparam int LIM_W = 2 * RADIUS_W + 2;

  localparam logic [MOUSE_W-1:0]  MOUSE_MAX  = MOUSE_W'(1599);
  localparam logic [RADIUS_W-1:0] RADIUS_MIN = RADIUS_W'(2);
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = RADIUS_W'(100);
  localparam logic [LIM_W-1:0]    LIM2_RST   = LIM_W'(16);
  localparam logic [COIN_W-1:0]   COIN_RST   = COIN_W'(1);

  // command codes
  localparam logic [CMD_W-1:0] OP_PAINT = 2'd0;
  localparam logic [CMD_W-1:0] OP_SWEEP = 2'd1;
  localparam logic [CMD_W-1:0] OP_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED   = 1'b1;

  // read address source
  typedef enum logic [2:0] {
    RD_CUR,
    RD_NEXT,
    RD_BELOW,
    RD_DIAG,
    RD_USER
  } rd_sel_t;

  // write operation
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO_CUR,
    WR_SET_BELOW,
    WR_SET_DIAG
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    in_ld;
    logic    pos_init;
    logic    pos_step;
    logic    sweep_mode;
    logic    paint_go;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    coin_step;
    logic    dir_ld;
    logic    below_ld;
    logic    below_clr;
    logic    raddr_ld;
    logic    res_cell;
    logic    out_ld;
  } fsgs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_cell;
    logic col_end;
    logic cell_occ;
    logic below_occ;
    logic diag_inside;
    logic paint_busy;
  } fsgs_sts_t;

endpackage
`default_nettype wire

/* sv/fsgs_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsgs_dpath: grid storage and arithmetic
// Holds the occupancy memory, scan counters, coin generator, brush pipeline,
// register file and the result registers. Acts on controller commands.
// ----------------------------------------------------------------------------
module fsgs_dpath import fsgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsgs_cmd_t             cmd,
  output fsgs_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [MOUSE_W-1:0]    in_mouse_x,
  input  logic [MOUSE_W-1:0]    in_mouse_y,
  input  logic [CELL_W-1:0]     in_cell_x,
  input  logic [CELL_W-1:0]     in_cell_y,
  output logic                  out_occupied
);

  function automatic logic [COIN_W-1:0] coin_adv(input logic [COIN_W-1:0] s);
    logic [COIN_W-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // latched beat fields
  logic [MOUSE_W-1:0] mx_r, my_r;
  logic [CELL_W-1:0]  cx_r, cy_r;

  // scan position
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          col_end, last_cell;

  // sweep state
  logic              below_r, dir_r;
  logic [COIN_W-1:0] coin_r, coin_nxt;
  logic              dir_w, diag_inside;
  logic [AW-1:0]     below_addr, next_addr, diag_addr;

  // registers
  logic [LIM_W-1:0]    lim2_r;
  logic [RADIUS_W-1:0] rad_clamp;
  logic [2*RADIUS_W-1:0] rad_sq;

  // brush pipeline
  logic                  p1_v_r, p2_v_r;
  logic signed [DW-1:0]  p1_dx_r, p1_dy_r, dx_w, dy_w;
  logic [AW-1:0]         p1_addr_r, p2_addr_r;
  logic signed [SQ_W-1:0] dx_ext, dy_ext;
  logic [SQ_W-1:0]       p2_dx2_r, p2_dy2_r;
  logic [SUM_W-1:0]      dist_sum;
  logic                  paint_hit;

  // cell read
  logic [AW-1:0] raddr_r;
  logic          rng_r, rng_w;

  // memory and results
  logic          occ_mem_r [CELL_COUNT];
  logic          mem_we, mem_wdata;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          rdata_r;
  logic          res_r, out_occ_r;

  // saturated mouse and cell latch on an accepted beat
  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      mx_r <= (in_mouse_x > MOUSE_MAX) ? MOUSE_MAX : in_mouse_x;
      my_r <= (in_mouse_y > MOUSE_MAX) ? MOUSE_MAX : in_mouse_y;
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
    end
  end

  // scan counters: sweep runs y from 1, clear and paint from 0
  assign col_end   = (y_r == YW'(GRID_HEIGHT - 1));
  assign last_cell = col_end && (x_r == XW'(GRID_WIDTH - 1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    addr_nxt = addr_r;
    if (cmd.pos_init) begin
      x_nxt    = '0;
      y_nxt    = cmd.sweep_mode ? YW'(1) : '0;
      addr_nxt = cmd.sweep_mode ? AW'(1) : '0;
    end else if (cmd.pos_step) begin
      if (col_end) begin
        x_nxt    = x_r + XW'(1);
        y_nxt    = cmd.sweep_mode ? YW'(1) : '0;
        addr_nxt = addr_r + (cmd.sweep_mode ? AW'(2) : AW'(1));
      end else begin
        y_nxt    = y_r + YW'(1);
        addr_nxt = addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      addr_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      addr_r <= addr_nxt;
    end
  end

  // coin generator and diagonal choice
  assign coin_nxt    = coin_adv(coin_r);
  assign dir_w       = coin_nxt[0];
  assign diag_inside = dir_w ? (x_r != XW'(GRID_WIDTH - 1)) : (x_r != '0);

  // clamp the radius and keep (2r)^2 as the brush threshold
  always_comb begin
    rad_clamp = cfg_data[RADIUS_W-1:0];
    if (rad_clamp < RADIUS_MIN) rad_clamp = RADIUS_MIN;
    if (rad_clamp > RADIUS_MAX) rad_clamp = RADIUS_MAX;
    rad_sq = (2*RADIUS_W)'(rad_clamp) * (2*RADIUS_W)'(rad_clamp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_r <= COIN_RST;
      lim2_r <= LIM2_RST;
    end else begin
      if (cfg_we && (cfg_index == CFG_IDX_SEED)) begin
        coin_r <= cfg_data[COIN_W-1:0];
      end else if (cmd.coin_step) begin
        coin_r <= coin_nxt;
      end
      if (cfg_we && (cfg_index == CFG_IDX_RADIUS)) begin
        lim2_r <= {rad_sq, 2'b00};
      end
    end
  end

  // below-cell tracker and latched coin side
  always_ff @(posedge clk) begin
    if (cmd.below_ld) begin
      below_r <= rdata_r;
    end else if (cmd.below_clr) begin
      below_r <= 1'b0;
    end
    if (cmd.dir_ld) begin
      dir_r <= dir_w;
    end
  end

  // neighbour addresses
  assign below_addr = addr_r - AW'(1);
  assign next_addr  = addr_r + AW'(1);
  assign diag_addr  = dir_r ? (below_addr + AW'(GRID_HEIGHT))
                            : (below_addr - AW'(GRID_HEIGHT));

  // brush pipeline: offsets, squares, then compare at the write port
  assign dx_w = $signed(DW'({x_r, 2'b00})) - $signed(DW'(mx_r));
  assign dy_w = $signed(DW'({y_r, 2'b00})) - $signed(DW'(my_r));
  assign dx_ext = SQ_W'(p1_dx_r);
  assign dy_ext = SQ_W'(p1_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.paint_go;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_dx_r   <= dx_w;
    p1_dy_r   <= dy_w;
    p1_addr_r <= addr_r;
    p2_dx2_r  <= $unsigned(dx_ext * dx_ext);
    p2_dy2_r  <= $unsigned(dy_ext * dy_ext);
    p2_addr_r <= p1_addr_r;
  end

  assign dist_sum  = {1'b0, p2_dx2_r} + {1'b0, p2_dy2_r};
  assign paint_hit = p2_v_r && (dist_sum < SUM_W'(lim2_r));

  // cell read address, range checked
  assign rng_w = (32'(cx_r) < GRID_WIDTH) && (32'(cy_r) < GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (cmd.raddr_ld) begin
      rng_r   <= rng_w;
      raddr_r <= rng_w ? AW'(AW'(cx_r) * AW'(GRID_HEIGHT) + AW'(cy_r)) : '0;
    end
  end

  // memory port selection
  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:   mem_raddr = addr_r;
      RD_NEXT:  mem_raddr = next_addr;
      RD_BELOW: mem_raddr = below_addr;
      RD_DIAG:  mem_raddr = diag_addr;
      RD_USER:  mem_raddr = raddr_r;
      default:  mem_raddr = addr_r;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = 1'b0;
    if (paint_hit) begin
      mem_we    = 1'b1;
      mem_waddr = p2_addr_r;
      mem_wdata = 1'b1;
    end else begin
      case (cmd.wr_sel)
        WR_ZERO_CUR: begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = 1'b0;
        end
        WR_SET_BELOW: begin
          mem_we    = 1'b1;
          mem_waddr = below_addr;
          mem_wdata = 1'b1;
        end
        WR_SET_DIAG: begin
          mem_we    = 1'b1;
          mem_waddr = diag_addr;
          mem_wdata = 1'b1;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // occupancy memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= occ_mem_r[mem_raddr];
    end
  end

  // result and output payload
  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      res_r <= 1'b0;
    end else if (cmd.res_cell) begin
      res_r <= rng_r & rdata_r;
    end
    if (cmd.out_ld) begin
      out_occ_r <= res_r;
    end
  end

  assign out_occupied = out_occ_r;

  // status
  assign sts.last_cell   = last_cell;
  assign sts.col_end     = col_end;
  assign sts.cell_occ    = rdata_r;
  assign sts.below_occ   = below_r;
  assign sts.diag_inside = diag_inside;
  assign sts.paint_busy  = p1_v_r | p2_v_r;

endmodule
`default_nettype wire

/* sv/fsgs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsgs_ctrl: sequencing state machine
// Clears the grid after reset, then takes one beat at a time and steps the
// datapath through paint, sweep or cell read; owns the output valid flag.
// ----------------------------------------------------------------------------
module fsgs_ctrl import fsgs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  output logic             out_valid,
  input  logic             out_stall,
  output fsgs_cmd_t        cmd,
  input  fsgs_sts_t        sts
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_PAINT  = 14'b00000000000100,
    S_PFLUSH = 14'b00000000001000,
    S_RADDR  = 14'b00000000010000,
    S_RMEM   = 14'b00000000100000,
    S_RDATA  = 14'b00000001000000,
    S_SBRD   = 14'b00000010000000,
    S_SBLD   = 14'b00000100000000,
    S_SEVAL  = 14'b00001000000000,
    S_SDRD   = 14'b00010000000000,
    S_SDEV   = 14'b00100000000000,
    S_SMV2   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   adv;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_CUR;
    cmd.wr_sel = WR_NONE;
    adv       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        cmd.wr_sel   = WR_ZERO_CUR;
        cmd.pos_step = 1'b1;
        if (sts.last_cell) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd.in_ld = 1'b1;
          case (in_command)
            OP_PAINT: begin
              cmd.pos_init = 1'b1;
              state_nxt    = S_PAINT;
            end
            OP_SWEEP: begin
              cmd.pos_init   = 1'b1;
              cmd.sweep_mode = 1'b1;
              state_nxt      = S_SBRD;
            end
            OP_READ: state_nxt = S_RADDR;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // one cell a cycle into the brush pipeline
      S_PAINT: begin
        cmd.paint_go = 1'b1;
        cmd.pos_step = 1'b1;
        if (sts.last_cell) state_nxt = S_PFLUSH;
      end

      S_PFLUSH: begin
        if (!sts.paint_busy) state_nxt = S_DONE;
      end

      S_RADDR: begin
        cmd.raddr_ld = 1'b1;
        state_nxt    = S_RMEM;
      end

      S_RMEM: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_USER;
        state_nxt  = S_RDATA;
      end

      S_RDATA: begin
        cmd.res_cell = 1'b1;
        state_nxt    = S_DONE;
      end

      // column start: fetch the bottom cell
      S_SBRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BELOW;
        state_nxt  = S_SBLD;
      end

      S_SBLD: begin
        cmd.below_ld = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_CUR;
        state_nxt    = S_SEVAL;
      end

      // current cell data is in the read register
      S_SEVAL: begin
        if (!sts.cell_occ) begin
          cmd.below_clr = 1'b1;
          adv           = 1'b1;
        end else if (!sts.below_occ) begin
          cmd.wr_sel = WR_SET_BELOW;
          state_nxt  = S_SMV2;
        end else begin
          cmd.coin_step = 1'b1;
          cmd.dir_ld    = 1'b1;
          if (sts.diag_inside) state_nxt = S_SDRD;
          else                 adv       = 1'b1;
        end
      end

      S_SDRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_DIAG;
        state_nxt  = S_SDEV;
      end

      S_SDEV: begin
        if (!sts.cell_occ) begin
          cmd.wr_sel = WR_SET_DIAG;
          state_nxt  = S_SMV2;
        end else begin
          adv = 1'b1;
        end
      end

      // grain has left the current cell
      S_SMV2: begin
        cmd.wr_sel    = WR_ZERO_CUR;
        cmd.below_clr = 1'b1;
        adv           = 1'b1;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // move on to the next sweep cell
    if (adv) begin
      if (sts.last_cell) begin
        state_nxt = S_DONE;
      end else begin
        cmd.pos_step   = 1'b1;
        cmd.sweep_mode = 1'b1;
        if (sts.col_end) begin
          state_nxt = S_SBRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_nxt  = S_SEVAL;
        end
      end
    end
  end

  // output valid
  always_comb begin
    if (cmd.out_ld)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/falling_sand_grid_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// falling_sand_grid_step: falling sand grid engine
// Occupancy grid with brush painting, in-place gravity sweep and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command (paint, sweep, read) with mouse and cell
//   fields; every accepted beat returns exactly one output beat, whose
//   occupied bit is the read cell for a read and 0 otherwise.
//   Registers (radius, coin seed) are written through the cfg port; the user
//   must write them only while idle, which the block does not enforce.
// Timing (N = 160000 cells, one occupancy memory port pair sets the pace):
//   read  : address latch, memory read, result register, output register.
//   paint : one cell per cycle through a three-stage pipeline.
//   sweep : row 0 skipped; one memory read per cell, a bottom-cell fetch at
//           each column start, a diagonal read when blocked, two writes a move.
//   One beat is in flight at a time; the next is accepted while the result
//   waits in the output register.
// Reset: synchronous; the block then clears the grid one cell per cycle
//   with in_stall high, and registers return to their reset values.
// Output stall: the result holds in the output register; a finished item
//   waits for it to drain before the next beat is taken.
// ----------------------------------------------------------------------------
module falling_sand_grid_step import fsgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [MOUSE_W-1:0]    in_mouse_x,
  input  logic [MOUSE_W-1:0]    in_mouse_y,
  input  logic [CELL_W-1:0]     in_cell_x,
  input  logic [CELL_W-1:0]     in_cell_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_occupied
);

  fsgs_cmd_t cmd;
  fsgs_sts_t sts;

  // sequencer
  fsgs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // grid memory and arithmetic
  fsgs_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mouse_x   (in_mouse_x),
    .in_mouse_y   (in_mouse_y),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .out_occupied (out_occupied)
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the falling sand grid engine
// Feeds paint, sweep, read and unused-command beats through a queued driver,
// mirrors the grid and the coin generator in a predictor, and checks every
// output beat against the oldest predicted occupied bit. Both sides idle at
// random; one long output hold-off backs the engine up.
// ----------------------------------------------------------------------------
module tb;
  import fsgs_pkg::*;

  localparam logic [CMD_W-1:0] OP_NONE = 2'd3;
  localparam int MOUSE_ALL     = (1 << MOUSE_W) - 1;
  localparam int CELL_ALL      = (1 << CELL_W) - 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 24_000_000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [MOUSE_W-1:0] mx;
    logic [MOUSE_W-1:0] my;
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
  } grid_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [MOUSE_W-1:0]    in_mouse_x = '0;
  logic [MOUSE_W-1:0]    in_mouse_y = '0;
  logic [CELL_W-1:0]     in_cell_x = '0;
  logic [CELL_W-1:0]     in_cell_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_occupied;

  falling_sand_grid_step i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_mouse_x   (in_mouse_x),
    .in_mouse_y   (in_mouse_y),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_occupied (out_occupied)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  bit                grain_map [GRID_WIDTH][GRID_HEIGHT];
  logic [COIN_W-1:0] coin_q = COIN_RST;
  int                brush_r = RADIUS_MIN;

  function automatic int sat_mouse(input int v);
    return (v > int'(MOUSE_MAX)) ? int'(MOUSE_MAX) : v;
  endfunction

  // xorshift 13/17/5, bit 0 of the new state picks the right-hand side
  function automatic bit flip_coin();
    logic [COIN_W-1:0] s;
    s = coin_q;
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    coin_q = s;
    return s[0];
  endfunction

  // brush: cells whose pixel point lies strictly inside the circle
  function automatic void lay_sand(input int mx_raw, input int my_raw);
    int mx, my, lim2, dx, dy;
    mx   = sat_mouse(mx_raw);
    my   = sat_mouse(my_raw);
    lim2 = 4 * brush_r * brush_r;
    for (int x = 0; x < GRID_WIDTH; x++) begin
      dx = 4 * x - mx;
      for (int y = 0; y < GRID_HEIGHT; y++) begin
        dy = 4 * y - my;
        if (dx * dx + dy * dy < lim2) grain_map[x][y] = 1'b1;
      end
    end
  endfunction

  // in-place gravity pass, column by column, bottom row stays put
  function automatic void settle_sand();
    int tx;
    for (int x = 0; x < GRID_WIDTH; x++) begin
      for (int y = 1; y < GRID_HEIGHT; y++) begin
        if (grain_map[x][y]) begin
          if (!grain_map[x][y-1]) begin
            grain_map[x][y]   = 1'b0;
            grain_map[x][y-1] = 1'b1;
          end else begin
            // coin is drawn even if the chosen side is off the grid
            tx = flip_coin() ? x + 1 : x - 1;
            if (tx >= 0 && tx < GRID_WIDTH && !grain_map[tx][y-1]) begin
              grain_map[x][y]    = 1'b0;
              grain_map[tx][y-1] = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  function automatic bit step_grid(input grid_req_t r);
    bit occ;
    occ = 1'b0;
    case (r.cmd)
      OP_PAINT: lay_sand(r.mx, r.my);
      OP_SWEEP: settle_sand();
      OP_READ: begin
        if (r.cx < GRID_WIDTH && r.cy < GRID_HEIGHT) occ = grain_map[r.cx][r.cy];
      end
      default: occ = 1'b0;
    endcase
    return occ;
  endfunction

  // ------------------------------------------------------------ shared state
  grid_req_t req_backlog[$];
  bit        occupied_due[$];
  int        reqs_issued = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        hold_wanted = 0;
  int        hold_started = 0;
  bit        calm = 1'b0;
  int        hot_x = 0;
  int        hot_y = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // ------------------------------------------------------------------ driver
  grid_req_t on_offer;
  int        gap_left = 0;

  always @(posedge clk) begin : drive_beats
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      // accepted beat: predict its result now
      if (in_valid && !in_stall) begin
        occupied_due = {occupied_due, step_grid(on_offer)};
        offer = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          on_offer   = req_backlog.pop_front();
          in_command <= on_offer.cmd;
          in_mouse_x <= on_offer.mx;
          in_mouse_y <= on_offer.my;
          in_cell_x  <= on_offer.cx;
          in_cell_y  <= on_offer.cy;
          offer      = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // ----------------------------------------------------------------- monitor
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin : watch_results
    bit want;
    bit stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (occupied_due.size() == 0) begin
          flag_mismatch("result beat with no expectation waiting");
        end else begin
          want = occupied_due.pop_front();
          if (out_occupied !== want)
            flag_mismatch($sformatf("occupied %b, expected %b", out_occupied, want));
        end
      end
      // long hold-off on request, otherwise short random bursts
      if (hold_started != hold_wanted) begin
        hold_started++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // --------------------------------------------------------------- watchdog
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_req(input int cmd, input int mx, input int my,
                          input int cx, input int cy);
    grid_req_t r;
    r.cmd = CMD_W'(cmd);
    r.mx  = MOUSE_W'(mx);
    r.my  = MOUSE_W'(my);
    r.cx  = CELL_W'(cx);
    r.cy  = CELL_W'(cy);
    req_backlog = {req_backlog, r};
    reqs_issued++;
  endtask

  function automatic int pick_near(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > CELL_ALL) v = CELL_ALL;
    return v;
  endfunction

  // read near the last brush stroke, or along the bottom where grains pile up
  task automatic probe_hot();
    int span, cx, cy;
    span = brush_r / 2 + 3;
    cx   = pick_near(hot_x, span);
    cy   = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 4)) : pick_near(hot_y, span);
    push_req(OP_READ, $urandom_range(0, MOUSE_ALL), $urandom_range(0, MOUSE_ALL), cx, cy);
  endtask

  task automatic paint_at(input int mx, input int my);
    push_req(OP_PAINT, mx, my, $urandom_range(0, CELL_ALL), $urandom_range(0, CELL_ALL));
    hot_x = sat_mouse(mx) / 4;
    hot_y = sat_mouse(my) / 4;
  endtask

  task automatic read_at(input int cx, input int cy);
    push_req(OP_READ, $urandom_range(0, MOUSE_ALL), $urandom_range(0, MOUSE_ALL), cx, cy);
  endtask

  task automatic sweep_once();
    push_req(OP_SWEEP, $urandom_range(0, MOUSE_ALL), $urandom_range(0, MOUSE_ALL),
             $urandom_range(0, CELL_ALL), $urandom_range(0, CELL_ALL));
  endtask

  task automatic random_phase(input int count, input bit heavy);
    int paint_k, sweep_k, roll, my;
    paint_k = heavy ? int'($urandom_range(0, count / 2)) : -1;
    sweep_k = heavy ? int'($urandom_range(count / 2 + 1, count - 1)) : -1;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (k == paint_k) begin
        // mostly low strokes so the sweeps meet resting grains
        my = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 300))
                                         : int'($urandom_range(0, MOUSE_ALL));
        paint_at($urandom_range(0, MOUSE_ALL), my);
      end else if (k == sweep_k) begin
        sweep_once();
      end else if (roll < 60) begin
        probe_hot();
      end else if (roll < 85) begin
        read_at($urandom_range(0, CELL_ALL), $urandom_range(0, CELL_ALL));
      end else begin
        push_req(OP_NONE, $urandom_range(0, MOUSE_ALL), $urandom_range(0, MOUSE_ALL),
                 $urandom_range(0, CELL_ALL), $urandom_range(0, CELL_ALL));
      end
    end
  endtask

  // block is idle once every beat has come back, plus a short margin
  task automatic wait_quiet();
    while (results_seen < reqs_issued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    int r;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_IDX_RADIUS) begin
      r = int'(val[RADIUS_W-1:0]);
      if (r < RADIUS_MIN) r = RADIUS_MIN;
      if (r > RADIUS_MAX) r = RADIUS_MAX;
      brush_r = r;
    end else if (idx == CFG_IDX_SEED) begin
      coin_q = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_random_regs();
    write_reg(CFG_IDX_RADIUS, $urandom_range(0, 127));
    write_reg(CFG_IDX_SEED, ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom());
  endtask

  initial begin : run_test
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: empty grid, out-of-range reads, unused command,
    // single-cell brush
    read_at(0, 0);
    read_at(CELL_ALL, CELL_ALL);
    read_at(GRID_WIDTH, 0);
    read_at(0, GRID_HEIGHT);
    push_req(OP_NONE, MOUSE_ALL, MOUSE_ALL, CELL_ALL, CELL_ALL);
    paint_at(8, 0);
    read_at(2, 0);
    read_at(1, 0);
    read_at(3, 0);
    wait_quiet();

    // radius above range clamps to the top, all-ones seed
    write_reg(CFG_IDX_RADIUS, 32'd127);
    write_reg(CFG_IDX_SEED, 32'hFFFF_FFFF);
    paint_at(800, 0);
    paint_at(MOUSE_ALL, MOUSE_ALL);
    read_at(200, 49);
    read_at(200, 50);
    read_at(350, 399);
    read_at(349, 399);
    sweep_once();
    read_at(399, 398);
    read_at(350, 398);
    sweep_once();
    read_at(200, 48);
    wait_quiet();

    // radius below range, zero seed: every coin says left
    write_reg(CFG_IDX_RADIUS, 32'd0);
    write_reg(CFG_IDX_SEED, 32'd0);
    paint_at(1200, MOUSE_ALL);
    read_at(300, 399);
    sweep_once();
    read_at(300, 398);
    read_at(300, 399);
    wait_quiet();

    // random phases, each from fresh register settings
    for (int p = 0; p < 3; p++) begin
      write_random_regs();
      random_phase(20, 1'b1);
      wait_quiet();
    end

    // receiver holds off while reads keep coming, so the input backs up
    hold_wanted++;
    random_phase(14, 1'b0);
    wait_quiet();

    // tail without idling on either side
    calm = 1'b1;
    random_phase(10, 1'b0);
    wait_quiet();

    if (occupied_due.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", occupied_due.size()));
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* falling_sand_grid_step.f */
sv/fsgs_pkg.sv
sv/fsgs_dpath.sv
sv/fsgs_ctrl.sv
sv/falling_sand_grid_step.sv
tb/tb.sv
